>>> rtl/nvap_pkg.sv
package nvap_pkg;

    localparam int VALUE_MAX_DEF      = 63;
    localparam int GUESTS_DEF         = 4;
    localparam int RESERVED_VALUE_DEF = 0;

    localparam int MAP_W   = 64;
    localparam int VALUE_W = 6;
    localparam int GUEST_W = 2;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN_GUEST = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FREE       = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_VALUE     = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } nvap_ctl_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] idx;
    } nvap_enc_t;

    function automatic nvap_enc_t lowest_set(input logic [MAP_W-1:0] v);
        nvap_enc_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r.found = 1'b1;
                r.idx   = VALUE_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/nvap_ctrl.sv
module nvap_ctrl
    import nvap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output nvap_ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/nvap_datapath.sv
module nvap_datapath
    import nvap_pkg::*;
#(
    parameter int VALUE_MAX      = VALUE_MAX_DEF,
    parameter int GUESTS         = GUESTS_DEF,
    parameter int RESERVED_VALUE = RESERVED_VALUE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  nvap_ctl_t          ctl,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [GUEST_W-1:0] guest,
    input  logic [VALUE_W-1:0] value,
    output logic [STAT_W-1:0]  status,
    output logic [VALUE_W-1:0] result_value,
    output logic               value_found,
    output logic               more_pending,
    output logic               doorbell
);

    localparam int GIDX_W = (GUESTS > 1) ? $clog2(GUESTS) : 1;
    localparam int GUESTS_W_EXT = 6;
    localparam logic [MAP_W:0] MASK_WIDE = (65'd1 << (VALUE_MAX + 1)) - 65'd1;
    localparam logic [MAP_W-1:0] MASK = MASK_WIDE[MAP_W-1:0];
    localparam logic [MAP_W-1:0] ALLOC_INIT = (64'd1 << RESERVED_VALUE) & MASK;

    logic [MAP_W-1:0] alloc_map_reg   [GUESTS];
    logic [MAP_W-1:0] pending_map_reg [GUESTS];

    logic [CMD_W-1:0]   cmd_reg;
    logic [GIDX_W-1:0]  gidx_reg;
    logic               known_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               in_range_reg;
    logic [MAP_W-1:0]   alloc_snap_reg;
    logic [MAP_W-1:0]   pend_snap_reg;

    logic [STAT_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0] result_reg, result_next;
    logic               valid_reg, valid_next;
    logic               more_reg, more_next;
    logic               bell_reg, bell_next;

    logic [MAP_W-1:0]  alloc_new, pend_new;
    logic              alloc_we, pend_we;
    logic              known_in;
    logic [GIDX_W-1:0] gidx_in;
    nvap_enc_t         free_enc, pend_enc;
    logic [MAP_W-1:0]  value_bit, pend_left;

    assign known_in = (GUESTS_W_EXT'(guest) < GUESTS_W_EXT'(GUESTS));
    assign gidx_in  = GIDX_W'(guest);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg      <= cmd;
            gidx_reg     <= gidx_in;
            known_reg    <= known_in;
            value_reg    <= value;
            in_range_reg <= ({1'b0, value} <= 7'(VALUE_MAX));
            alloc_snap_reg <= known_in ? alloc_map_reg[gidx_in] : '0;
            pend_snap_reg  <= known_in ? pending_map_reg[gidx_in] : '0;
        end
    end

    assign free_enc  = lowest_set(~alloc_snap_reg & MASK);
    assign pend_enc  = lowest_set(pend_snap_reg & MASK);
    assign value_bit = MAP_W'(1) << value_reg;
    assign pend_left = pend_snap_reg & MASK & ~(MAP_W'(1) << pend_enc.idx);

    always_comb
    begin
        status_next = ST_OK;
        result_next = '0;
        valid_next  = 1'b0;
        more_next   = 1'b0;
        bell_next   = 1'b0;
        alloc_new   = alloc_snap_reg;
        pend_new    = pend_snap_reg;
        alloc_we    = 1'b0;
        pend_we     = 1'b0;
        if (!known_reg)
        begin
            status_next = ST_UNKNOWN_GUEST;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (!free_enc.found)
                    begin
                        status_next = ST_NO_FREE;
                    end
                    else
                    begin
                        result_next = free_enc.idx;
                        alloc_new   = alloc_snap_reg | (MAP_W'(1) << free_enc.idx);
                        alloc_we    = 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    if (!in_range_reg || !(|(alloc_snap_reg & value_bit)))
                    begin
                        status_next = ST_BAD_VALUE;
                    end
                    else
                    begin
                        alloc_new = alloc_snap_reg & ~value_bit;
                        alloc_we  = 1'b1;
                    end
                end
                CMD_SEND:
                begin
                    if (!in_range_reg)
                    begin
                        status_next = ST_BAD_VALUE;
                    end
                    else
                    begin
                        pend_new  = pend_snap_reg | value_bit;
                        pend_we   = 1'b1;
                        bell_next = 1'b1;
                    end
                end
                CMD_GET:
                begin
                    if (pend_enc.found)
                    begin
                        valid_next  = 1'b1;
                        result_next = pend_enc.idx;
                        pend_new    = pend_left;
                        pend_we     = 1'b1;
                        more_next   = |pend_left;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GUESTS; g++)
            begin
                alloc_map_reg[g]   <= ALLOC_INIT;
                pending_map_reg[g] <= '0;
            end
        end
        else if (ctl.exec)
        begin
            if (alloc_we)
            begin
                alloc_map_reg[gidx_reg] <= alloc_new;
            end
            if (pend_we)
            begin
                pending_map_reg[gidx_reg] <= pend_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
            valid_reg  <= valid_next;
            more_reg   <= more_next;
            bell_reg   <= bell_next;
        end
    end

    assign status       = status_reg;
    assign result_value = result_reg;
    assign value_found  = valid_reg;
    assign more_pending = more_reg;
    assign doorbell     = bell_reg;

endmodule

>>> rtl/notify_value_alloc_and_pending.sv
// Channel  | Ports                                       | Transfer
// ---------+---------------------------------------------+---------------------------
// command  | cmd, guest, value                           | start & !busy at clk edge
// result   | status, result_value, value_found,          | done high for one cycle
//          | more_pending, doorbell                      |
//
// The transfer edge captures the operands and the guest's maps; an idle load cycle
// and a read-modify-write cycle with the priority encoders follow, and done is
// registered at the end of the read-modify-write; busy is high through both.
// A new command can be taken in the cycle in which done is high.
// rst_n is asynchronous; it puts every map back to its reset contents at once.
// The receiver cannot stall: done marks each result for exactly one cycle.
module notify_value_alloc_and_pending
    import nvap_pkg::*;
#(
    parameter int VALUE_MAX      = VALUE_MAX_DEF,
    parameter int GUESTS         = GUESTS_DEF,
    parameter int RESERVED_VALUE = RESERVED_VALUE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [GUEST_W-1:0] guest,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [VALUE_W-1:0] result_value,
    output logic               value_found,
    output logic               more_pending,
    output logic               doorbell
);

    nvap_ctl_t ctl;

    nvap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    nvap_datapath #(
        .VALUE_MAX      (VALUE_MAX),
        .GUESTS         (GUESTS),
        .RESERVED_VALUE (RESERVED_VALUE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (cmd),
        .guest        (guest),
        .value        (value),
        .status       (status),
        .result_value (result_value),
        .value_found  (value_found),
        .more_pending (more_pending),
        .doorbell     (doorbell)
    );

endmodule
